/* design/pmle_pkg.sv */
// Shared types, character codes and sizing for the movetext main-line extractor.
// No dependencies; every other design file imports this package.

package pmle_pkg;

   // Move token storage
   localparam int MOVE_MAX   = 16;
   localparam int TOK_IDX_W  = $clog2(MOVE_MAX);
   localparam int TOK_LEN_W  = $clog2(MOVE_MAX + 1);

   // Marker search phases
   localparam logic [1:0] SEEK_NONE  = 2'd0;
   localparam logic [1:0] SEEK_AT    = 2'd1;
   localparam logic [1:0] SEEK_FOUND = 2'd2;

   // Parse modes
   localparam logic [1:0] MODE_MAIN = 2'd0;
   localparam logic [1:0] MODE_MOVE = 2'd1;
   localparam logic [1:0] MODE_VAR  = 2'd2;
   localparam logic [1:0] MODE_CMT  = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_AT      = "@";
   localparam logic [7:0] CH_M       = "M";
   localparam logic [7:0] CH_LBRACE  = "{";
   localparam logic [7:0] CH_RBRACE  = "}";
   localparam logic [7:0] CH_LPAREN  = "(";
   localparam logic [7:0] CH_RPAREN  = ")";
   localparam logic [7:0] CH_PERCENT = "%";
   localparam logic [7:0] CH_PLUS    = "+";
   localparam logic [7:0] CH_HASH    = "#";
   localparam logic [7:0] CH_DASH    = "-";
   localparam logic [7:0] CH_EQUAL   = "=";

   localparam logic [7:0]  DEPTH_MAX = 8'hFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic KIND_MOVE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        marker_found;
      logic        saw_variation;
      logic        saw_comment;
      logic        comments_all_automatic;
      logic [15:0] comment_total;
   } summary_type;

   // One parse step, handed from the parser to the top level
   typedef struct packed {
      logic                 wr_en;
      logic [TOK_IDX_W-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 emit;
      logic [TOK_LEN_W-1:0] emit_len;
      logic                 emit_ovf;
      logic                 eot;
      summary_type          summary;
   } step_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  move_char;
      logic        move_end;
      logic        move_truncated;
      summary_type summary;
      logic        last;
   } rsp_type;

endpackage

/* design/pmle_req_if.sv */
// Input channel: one text byte per transfer with an end-of-text flag.
// Depends on pmle_pkg.

interface pmle_req_if import pmle_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

/* design/pmle_rsp_if.sv */
// Result channel: move characters and the end-of-record summary.
// Depends on pmle_pkg.

interface pmle_rsp_if import pmle_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  move_char;
   logic        move_end;
   logic        move_truncated;
   logic        marker_found;
   logic        saw_variation;
   logic        saw_comment;
   logic        comments_all_automatic;
   logic [15:0] comment_total;
   logic        last;

   modport source (output valid, kind, move_char, move_end, move_truncated, marker_found,
                   saw_variation, saw_comment, comments_all_automatic, comment_total, last,
                   input ready);
   modport sink   (input valid, kind, move_char, move_end, move_truncated, marker_found,
                   saw_variation, saw_comment, comments_all_automatic, comment_total, last,
                   output ready);
endinterface

/* design/pgn_movetext_main_line_extractor.sv */
// Top level: parser, token RAM, emit sequencer and registered result stage.
// Depends on pmle_pkg, pmle_req_if, pmle_rsp_if and pmle_parser.
//
//   Channel | Dir | Transfer carries                        | Handshake
//   --------+-----+-----------------------------------------+------------
//   req_ch  | in  | text_byte, end_of_text                  | valid/ready
//   rsp_ch  | out | move character or end-of-record summary | valid/ready
//
// A byte is parsed in the cycle it transfers; bytes that end no move and no
// record go one per cycle. A byte that ends a move holds req_ch off while the
// token RAM, one read port with registered data, feeds its characters out at
// one per cycle while rsp_ch takes them; end of text adds the summary.
// Reset (synchronous) clears all parse state; the token RAM is not cleared. A
// stalled rsp_ch holds the sequencer in place; a byte may still transfer while
// the last result waits in the output register.

module pgn_movetext_main_line_extractor import pmle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pmle_req_if.sink   req_ch,
   pmle_rsp_if.source rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [TOK_LEN_W-1:0] rd_idx_ff, rd_idx_in;   // next RAM entry to read
   logic [TOK_LEN_W-1:0] q_idx_ff, q_idx_in;     // entry held in RAM read data
   logic                 q_vld_ff, q_vld_in;
   logic [TOK_LEN_W-1:0] emit_len_ff, emit_len_in;
   logic                 emit_ovf_ff, emit_ovf_in;
   logic                 sum_pend_ff, sum_pend_in;
   summary_type          sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   step_type             step;
   logic                 accept;
   logic                 out_free;
   logic                 rd_en;
   logic                 load_char;
   logic                 char_final;
   logic                 load_sum;

   logic [7:0]           tok_mem [MOVE_MAX];
   logic [7:0]           mem_q;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;

   pmle_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .text_byte   (req_ch.text_byte),
      .end_of_text (req_ch.end_of_text),
      .step        (step)
   );

   // output register is free when empty or its result transfers this cycle
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign rd_en      = (state_ff == ST_EMIT) && (rd_idx_ff < emit_len_ff) &&
                       (!q_vld_ff || out_free);
   assign load_char  = (state_ff == ST_EMIT) && q_vld_ff && out_free;
   assign char_final = ((q_idx_ff + 1'b1) == emit_len_ff);
   assign load_sum   = (state_ff == ST_SUM) && out_free;

   // token RAM: writes only while parsing, reads only while emitting
   always_ff @(posedge clock) begin
      if (step.wr_en && accept) tok_mem[step.wr_addr] <= step.wr_data;
      if (rd_en) mem_q <= tok_mem[rd_idx_ff[TOK_IDX_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      q_idx_in     = q_idx_ff;
      q_vld_in     = q_vld_ff;
      emit_len_in  = emit_len_ff;
      emit_ovf_in  = emit_ovf_ff;
      sum_pend_in  = sum_pend_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in      = step.summary;
               sum_pend_in = step.eot;
               if (step.emit) begin
                  state_in    = ST_EMIT;
                  rd_idx_in   = '0;
                  q_vld_in    = 1'b0;
                  emit_len_in = step.emit_len;
                  emit_ovf_in = step.emit_ovf;
               end else if (step.eot) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_EMIT: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               q_idx_in  = rd_idx_ff;
               q_vld_in  = 1'b1;
            end else if (load_char) begin
               q_vld_in = 1'b0;
            end
            if (load_char) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.kind           = KIND_MOVE;
               rsp_in.move_char      = mem_q;
               rsp_in.move_end       = char_final;
               rsp_in.move_truncated = emit_ovf_ff;
               rsp_in.last           = char_final && !sum_pend_ff;
               if (char_final) state_in = sum_pend_ff ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            if (load_sum) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.kind    = KIND_SUMMARY;
               rsp_in.summary = sum_ff;
               rsp_in.last    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_vld_ff     <= q_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_pend_ff  <= sum_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      q_idx_ff    <= q_idx_in;
      emit_len_ff <= emit_len_in;
      emit_ovf_ff <= emit_ovf_in;
      sum_ff      <= sum_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_ch.valid                  = rsp_valid_ff;
   assign rsp_ch.kind                   = rsp_ff.kind;
   assign rsp_ch.move_char              = rsp_ff.move_char;
   assign rsp_ch.move_end               = rsp_ff.move_end;
   assign rsp_ch.move_truncated         = rsp_ff.move_truncated;
   assign rsp_ch.marker_found           = rsp_ff.summary.marker_found;
   assign rsp_ch.saw_variation          = rsp_ff.summary.saw_variation;
   assign rsp_ch.saw_comment            = rsp_ff.summary.saw_comment;
   assign rsp_ch.comments_all_automatic = rsp_ff.summary.comments_all_automatic;
   assign rsp_ch.comment_total          = rsp_ff.summary.comment_total;
   assign rsp_ch.last                   = rsp_ff.last;

endmodule

/* design/pmle_parser.sv */
// Byte-level parser: marker search, mode tracking, token bookkeeping, summary flags.
// Depends on pmle_pkg; drives the token RAM writes through step_type.

module pmle_parser import pmle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   output step_type   step
);

   logic [1:0]           seek_ff, seek_in;
   logic [1:0]           mode_ff, mode_in;
   logic [1:0]           resume_ff, resume_in;
   logic [7:0]           depth_ff, depth_in;
   logic [TOK_LEN_W-1:0] tok_len_ff, tok_len_in;
   logic                 tok_ovf_ff, tok_ovf_in;
   logic                 pct_ff, pct_in;
   logic                 var_seen_ff, var_seen_in;
   logic                 cmt_seen_ff, cmt_seen_in;
   logic                 only_auto_ff, only_auto_in;
   logic [15:0]          cmt_cnt_ff, cmt_cnt_in;

   always_comb begin
      logic                 is_letter;
      logic                 is_digit;
      logic                 tok_start;
      logic                 tok_add;
      logic [TOK_LEN_W-1:0] base_len;
      logic                 base_ovf;
      logic [7:0]           depth_dec;

      is_letter = text_byte inside {["A":"Z"], ["a":"z"]};
      is_digit  = text_byte inside {["0":"9"]};
      tok_start = 1'b0;
      tok_add   = 1'b0;
      base_len  = '0;
      base_ovf  = 1'b0;
      depth_dec = depth_ff;

      seek_in      = seek_ff;
      mode_in      = mode_ff;
      resume_in    = resume_ff;
      depth_in     = depth_ff;
      tok_len_in   = tok_len_ff;
      tok_ovf_in   = tok_ovf_ff;
      pct_in       = pct_ff;
      var_seen_in  = var_seen_ff;
      cmt_seen_in  = cmt_seen_ff;
      only_auto_in = only_auto_ff;
      cmt_cnt_in   = cmt_cnt_ff;

      step         = '0;
      step.wr_data = text_byte;
      step.eot     = end_of_text;

      if (seek_ff != SEEK_FOUND) begin
         if (seek_ff == SEEK_AT && text_byte == CH_M) begin
            seek_in = SEEK_FOUND;
         end else if (text_byte == CH_AT) begin
            seek_in = SEEK_AT;
         end else begin
            seek_in = SEEK_NONE;
         end
      end else begin
         case (mode_ff)
            MODE_MAIN: begin
               if (text_byte == CH_LBRACE) begin
                  mode_in = MODE_CMT;
               end else if (text_byte == CH_LPAREN) begin
                  mode_in     = MODE_VAR;
                  var_seen_in = 1'b1;
                  depth_in    = 8'd1;
               end else if (is_letter && text_byte != CH_M) begin
                  mode_in   = MODE_MOVE;
                  tok_start = 1'b1;
               end
            end
            MODE_MOVE: begin
               if (text_byte == CH_LBRACE) begin
                  mode_in = MODE_CMT;
               end else if (text_byte == CH_LPAREN) begin
                  mode_in     = MODE_VAR;
                  var_seen_in = 1'b1;
                  depth_in    = 8'd1;
               end else if (text_byte == CH_PLUS || text_byte == CH_HASH) begin
                  tok_add = 1'b1;
                  mode_in = MODE_MAIN;
               end else if (is_letter || is_digit || text_byte == CH_DASH ||
                            text_byte == CH_EQUAL) begin
                  tok_add = 1'b1;
               end else begin
                  mode_in = MODE_MAIN;
               end
            end
            MODE_VAR: begin
               if (text_byte == CH_LBRACE) begin
                  mode_in = MODE_CMT;
               end else if (text_byte == CH_LPAREN) begin
                  if (depth_ff != DEPTH_MAX) depth_in = depth_ff + 8'd1;
               end else if (text_byte == CH_RPAREN) begin
                  if (depth_ff != 8'd0) depth_dec = depth_ff - 8'd1;
                  depth_in = depth_dec;
                  if (depth_dec == 8'd0) mode_in = MODE_MAIN;
               end
            end
            default: begin
               if (text_byte == CH_PERCENT) begin
                  pct_in = 1'b1;
               end else if (text_byte == CH_RBRACE) begin
                  if (!pct_ff) only_auto_in = 1'b0;
                  mode_in = resume_ff;
               end
            end
         endcase

         // token append; a new token restarts length and overflow
         base_len = tok_start ? '0 : tok_len_ff;
         base_ovf = tok_start ? 1'b0 : tok_ovf_ff;
         if (tok_start) begin
            tok_len_in = '0;
            tok_ovf_in = 1'b0;
         end
         if (tok_start || tok_add) begin
            if (base_len < TOK_LEN_W'(MOVE_MAX)) begin
               step.wr_en   = 1'b1;
               step.wr_addr = base_len[TOK_IDX_W-1:0];
               tok_len_in   = base_len + 1'b1;
               tok_ovf_in   = base_ovf;
            end else begin
               tok_ovf_in = 1'b1;
            end
         end

         if (mode_in != mode_ff) begin
            if (mode_in == MODE_CMT) begin
               if (cmt_cnt_ff != COUNT_MAX) cmt_cnt_in = cmt_cnt_ff + 16'd1;
               cmt_seen_in = 1'b1;
               pct_in      = 1'b0;
               resume_in   = mode_ff;
            end else if (mode_ff == MODE_MOVE) begin
               step.emit     = 1'b1;
               step.emit_len = tok_len_in;
               step.emit_ovf = tok_ovf_in;
               tok_len_in    = '0;
               tok_ovf_in    = 1'b0;
            end
         end
      end

      step.summary.marker_found           = (seek_in == SEEK_FOUND);
      step.summary.saw_variation          = var_seen_in;
      step.summary.saw_comment            = cmt_seen_in;
      step.summary.comments_all_automatic = cmt_seen_in & only_auto_in;
      step.summary.comment_total          = cmt_cnt_in;

      // record done: next byte starts a fresh record
      if (end_of_text) begin
         seek_in      = SEEK_NONE;
         mode_in      = MODE_MAIN;
         resume_in    = MODE_MAIN;
         depth_in     = 8'd0;
         tok_len_in   = '0;
         tok_ovf_in   = 1'b0;
         pct_in       = 1'b0;
         var_seen_in  = 1'b0;
         cmt_seen_in  = 1'b0;
         only_auto_in = 1'b1;
         cmt_cnt_in   = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seek_ff      <= SEEK_NONE;
         mode_ff      <= MODE_MAIN;
         resume_ff    <= MODE_MAIN;
         depth_ff     <= 8'd0;
         tok_len_ff   <= '0;
         tok_ovf_ff   <= 1'b0;
         pct_ff       <= 1'b0;
         var_seen_ff  <= 1'b0;
         cmt_seen_ff  <= 1'b0;
         only_auto_ff <= 1'b1;
         cmt_cnt_ff   <= 16'd0;
      end else if (step_en) begin
         seek_ff      <= seek_in;
         mode_ff      <= mode_in;
         resume_ff    <= resume_in;
         depth_ff     <= depth_in;
         tok_len_ff   <= tok_len_in;
         tok_ovf_ff   <= tok_ovf_in;
         pct_ff       <= pct_in;
         var_seen_ff  <= var_seen_in;
         cmt_seen_ff  <= cmt_seen_in;
         only_auto_ff <= only_auto_in;
         cmt_cnt_ff   <= cmt_cnt_in;
      end
   end

endmodule

/* sim/pgn_movetext_main_line_extractor_tb.sv */
// Self-checking testbench for the movetext main-line extractor.
// Drives game records byte by byte and checks move characters and summaries
// against an in-bench parser. Depends on pmle_pkg, pmle_req_if, pmle_rsp_if.
`timescale 1ns / 100ps

module pgn_movetext_main_line_extractor_tb import pmle_pkg::*; ();

   // A run of this many cycles with no transfer on either side is a hang.
   localparam int QUIET_LIMIT   = 5000;
   localparam int BYTES_PER_RUN = 80;
   localparam int LONG_HOLD     = 400;
   localparam int TAIL_CYCLES   = 20;

   localparam logic [7:0] CH_SPACE   = " ";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_ZERO    = "0";

   typedef struct {
      logic [7:0] text_byte;
      logic       eot;
   } text_item_type;

   logic clock;
   logic reset;

   pmle_req_if req_ch ();
   pmle_rsp_if rsp_ch ();

   pgn_movetext_main_line_extractor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Bytes waiting to be offered and results the scanner has predicted.
   text_item_type pending_text[$];
   rsp_type       predicted_output[$];

   int  bytes_queued  = 0;
   int  bytes_taken   = 0;
   int  results_seen  = 0;
   int  mismatches    = 0;
   int  quiet_cycles  = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  req_taken     = 1'b0;
   bit  long_hold_go  = 1'b0;
   bit  long_hold_done = 1'b0;
   int  hold_left     = 0;

   // ---------------------------------------------------------------------
   // Scanner: tracks the same parse state as the block and predicts output
   // ---------------------------------------------------------------------
   logic [1:0]  scan_seek;
   logic [1:0]  scan_mode;
   logic [1:0]  scan_resume;
   logic [7:0]  scan_depth;
   logic [7:0]  scan_tok [MOVE_MAX];
   int          scan_len;
   logic        scan_ovf;
   logic        scan_pct;
   logic        scan_var_seen;
   logic        scan_cmt_seen;
   logic        scan_only_auto;
   logic [15:0] scan_cmt_count;

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Back to the start-of-record state; the token store keeps its contents.
   task automatic rewind_scanner();
      scan_seek      = SEEK_NONE;
      scan_mode      = MODE_MAIN;
      scan_resume    = MODE_MAIN;
      scan_depth     = '0;
      scan_len       = 0;
      scan_ovf       = 1'b0;
      scan_pct       = 1'b0;
      scan_var_seen  = 1'b0;
      scan_cmt_seen  = 1'b0;
      scan_only_auto = 1'b1;
      scan_cmt_count = '0;
   endtask

   // Characters past capacity are lost but mark the whole move truncated.
   task automatic add_char(input logic [7:0] c);
      if (scan_len < MOVE_MAX) begin
         scan_tok[TOK_IDX_W'(scan_len)] = c;
         scan_len++;
      end else begin
         scan_ovf = 1'b1;
      end
   endtask

   task automatic scan_byte(input logic [7:0] c, input logic eot);
      logic [1:0] prior;
      logic [1:0] next;
      rsp_type    r;
      rsp_type    produced[$];
      if (scan_seek != SEEK_FOUND) begin
         // Still hunting for the move-section marker.
         if (scan_seek == SEEK_AT && c == CH_M)
            scan_seek = SEEK_FOUND;
         else if (c == CH_AT)
            scan_seek = SEEK_AT;
         else
            scan_seek = SEEK_NONE;
      end else begin
         prior = scan_mode;
         next  = prior;
         case (prior)
            MODE_MAIN: begin
               if (c == CH_LBRACE) begin
                  next = MODE_CMT;
               end else if (c == CH_LPAREN) begin
                  next = MODE_VAR;
                  scan_var_seen = 1'b1;
                  scan_depth = 8'd1;
               end else if (c != CH_M && is_alpha(c)) begin
                  next = MODE_MOVE;
                  scan_len = 0;
                  scan_ovf = 1'b0;
                  add_char(c);
               end
            end
            MODE_MOVE: begin
               if (c == CH_LBRACE) begin
                  next = MODE_CMT;
               end else if (c == CH_LPAREN) begin
                  next = MODE_VAR;
                  scan_var_seen = 1'b1;
                  scan_depth = 8'd1;
               end else if (c == CH_PLUS || c == CH_HASH) begin
                  add_char(c);
                  next = MODE_MAIN;
               end else if (is_alpha(c) || is_numeral(c) || c == CH_DASH || c == CH_EQUAL) begin
                  add_char(c);
               end else begin
                  next = MODE_MAIN;
               end
            end
            MODE_VAR: begin
               if (c == CH_LBRACE) begin
                  next = MODE_CMT;
               end else if (c == CH_LPAREN) begin
                  if (scan_depth != DEPTH_MAX)
                     scan_depth++;
               end else if (c == CH_RPAREN) begin
                  if (scan_depth != 0)
                     scan_depth--;
                  if (scan_depth == 0)
                     next = MODE_MAIN;
               end
            end
            default: begin
               if (c == CH_PERCENT) begin
                  scan_pct = 1'b1;
               end else if (c == CH_RBRACE) begin
                  if (!scan_pct)
                     scan_only_auto = 1'b0;
                  next = scan_resume;
               end
            end
         endcase
         if (next != prior) begin
            if (next == MODE_CMT) begin
               // Entering a comment; an open move is only suspended.
               if (scan_cmt_count != COUNT_MAX)
                  scan_cmt_count++;
               scan_cmt_seen = 1'b1;
               scan_pct = 1'b0;
               scan_resume = prior;
            end else if (prior == MODE_MOVE) begin
               for (int i = 0; i < scan_len; i++) begin
                  r = '0;
                  r.kind = KIND_MOVE;
                  r.move_char = scan_tok[TOK_IDX_W'(i)];
                  r.move_end = (i == scan_len - 1);
                  r.move_truncated = scan_ovf;
                  produced = {produced, r};
               end
               scan_len = 0;
               scan_ovf = 1'b0;
            end
         end
         scan_mode = next;
      end
      if (eot) begin
         // An open move is dropped; an open comment leaves the flag alone.
         r = '0;
         r.kind = KIND_SUMMARY;
         r.summary.marker_found = (scan_seek == SEEK_FOUND);
         r.summary.saw_variation = scan_var_seen;
         r.summary.saw_comment = scan_cmt_seen;
         r.summary.comments_all_automatic = scan_cmt_seen && scan_only_auto;
         r.summary.comment_total = scan_cmt_count;
         produced = {produced, r};
         rewind_scanner();
      end
      if (produced.size() != 0)
         produced[produced.size() - 1].last = 1'b1;
      predicted_output = {predicted_output, produced};
   endtask

   // ---------------------------------------------------------------------
   // Record text generation
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] c, input logic eot);
      text_item_type t;
      t.text_byte = c;
      t.eot = eot;
      pending_text = {pending_text, t};
      bytes_queued++;
   endtask

   task automatic push_text(input string s, input bit eot_on_last = 1'b0);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], eot_on_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] pick_move_char();
      case ($urandom_range(3))
         0: return CH_LOWER_A + 8'($urandom_range(25));
         1: return CH_UPPER_A + 8'($urandom_range(25));
         2: return CH_ZERO + 8'($urandom_range(9));
         default: return $urandom_range(1) ? CH_DASH : CH_EQUAL;
      endcase
   endfunction

   // Mostly short SAN-like tokens, now and then one past the token capacity.
   task automatic push_move();
      int n;
      n = ($urandom_range(7) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      push_byte(CH_LOWER_A + 8'($urandom_range(7)), 1'b0);
      repeat (n - 1)
         push_byte(pick_move_char(), 1'b0);
      case ($urandom_range(5))
         0: push_byte(CH_PLUS, 1'b0);
         1: push_byte(CH_HASH, 1'b0);
         default: ;
      endcase
   endtask

   task automatic push_comment();
      logic [7:0] c;
      push_byte(CH_LBRACE, 1'b0);
      if ($urandom_range(9) < 6)
         push_text("%clk ");
      repeat ($urandom_range(6)) begin
         c = 8'($urandom_range(255));
         push_byte((c == CH_RBRACE) ? CH_PERCENT : c, 1'b0);
      end
      push_byte(CH_RBRACE, 1'b0);
   endtask

   task automatic push_element(input int depth);
      case ($urandom_range(11))
         0, 1: push_text($sformatf("%0d. ", $urandom_range(1, 99)));
         2, 3, 4: begin
            push_move();
            push_byte(CH_SPACE, 1'b0);
         end
         5: push_comment();
         6: begin
            // comment splitting a move token
            push_move();
            push_comment();
            push_move();
            push_byte(CH_SPACE, 1'b0);
         end
         7: begin
            if (depth < 3) begin
               push_byte(CH_LPAREN, 1'b0);
               repeat ($urandom_range(4)) push_element(depth + 1);
               push_byte(CH_RPAREN, 1'b0);
            end else begin
               push_move();
            end
         end
         8: push_byte(8'($urandom_range(255)), 1'b0);
         9: push_byte($urandom_range(1) ? CH_M : CH_RPAREN, 1'b0);
         default: push_move();
      endcase
   endtask

   task automatic push_record();
      repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
      case ($urandom_range(9))
         0: ;
         1: push_text("@@M");
         2: push_text("@ M");
         default: push_text("@M");
      endcase
      repeat ($urandom_range(8, 2)) push_element(0);
      case ($urandom_range(3))
         0: push_byte(CH_SPACE, 1'b1);
         1: push_byte(pick_move_char(), 1'b1);
         2: push_byte(CH_RBRACE, 1'b1);
         default: push_byte(8'($urandom_range(255)), 1'b1);
      endcase
   endtask

   task automatic wait_for_drain();
      while (bytes_taken != bytes_queued || predicted_output.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers one byte per transfer, idles at the current rate
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      text_item_type t;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            t = pending_text.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.text_byte <= t.text_byte;
            req_ch.end_of_text <= t.eot;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (long_hold_go && !long_hold_done) begin
         hold_left = LONG_HOLD;
         long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each byte transfer, then check each result transfer
   // ---------------------------------------------------------------------
   task automatic log_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want)
         log_mismatch($sformatf("result %0d %s: expected %h, got %h",
                                results_seen, name, want, got));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (req_taken) begin
         scan_byte(req_ch.text_byte, req_ch.end_of_text);
         bytes_taken++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (predicted_output.size() == 0) begin
            log_mismatch($sformatf("result %0d unexpected: kind %0d char %h last %0d",
                                   results_seen, rsp_ch.kind, rsp_ch.move_char,
                                   rsp_ch.last));
         end else begin
            want = predicted_output.pop_front();
            compare_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
            compare_field("move_char", 16'(want.move_char), 16'(rsp_ch.move_char));
            compare_field("move_end", 16'(want.move_end), 16'(rsp_ch.move_end));
            compare_field("move_truncated", 16'(want.move_truncated),
                          16'(rsp_ch.move_truncated));
            compare_field("marker_found", 16'(want.summary.marker_found),
                          16'(rsp_ch.marker_found));
            compare_field("saw_variation", 16'(want.summary.saw_variation),
                          16'(rsp_ch.saw_variation));
            compare_field("saw_comment", 16'(want.summary.saw_comment),
                          16'(rsp_ch.saw_comment));
            compare_field("comments_all_automatic",
                          16'(want.summary.comments_all_automatic),
                          16'(rsp_ch.comments_all_automatic));
            compare_field("comment_total", want.summary.comment_total,
                          rsp_ch.comment_total);
            compare_field("last", 16'(want.last), 16'(rsp_ch.last));
         end
      end
   end

   // Watchdog: any transfer restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("pgn_movetext_main_line_extractor_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, then four idling runs, each drained before the next
   // ---------------------------------------------------------------------
   initial begin
      static int send_pct [4] = '{0, 60, 0, 11};
      static int recv_pct [4] = '{0, 0, 60, 11};
      int run_start;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.text_byte = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready = 1'b0;
      rewind_scanner();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      for (int run = 0; run < 4; run++) begin
         send_idle_pct = send_pct[run];
         recv_stall_pct = recv_pct[run];
         if (run == 0) begin
            // No marker: letters are ignored and the summary says so.
            push_text("e4", 1'b1);
            // Double '@', ignored 'M', every move terminator, comment inside a
            // move, high byte ending a move, nested variation, move open at end.
            push_text("@@MMa-1=Q{%c}b+ c#d");
            push_byte(8'h80, 1'b0);
            push_text("e({}()))f", 1'b1);
            // Unclosed automatic comment at end of text.
            push_text("@M{%", 1'b1);
            long_hold_go = 1'b1;
         end
         run_start = bytes_queued;
         while (bytes_queued - run_start < BYTES_PER_RUN)
            push_record();
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (predicted_output.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", predicted_output.size()));
      if (mismatches == 0)
         $display("pgn_movetext_main_line_extractor_tb: clean");
      else
         $display("pgn_movetext_main_line_extractor_tb: errors");
      $finish;
   end

endmodule

/* files.f */
design/pmle_pkg.sv
design/pmle_req_if.sv
design/pmle_rsp_if.sv
design/pmle_parser.sv
design/pgn_movetext_main_line_extractor.sv
sim/pgn_movetext_main_line_extractor_tb.sv
